[hw/rtl/sdr_pkg.sv]
// Shared types, constants and saturating adder for the spatial difference reconstruct unit.
package sdr_pkg;

  localparam int ACC_W      = 48;
  localparam int VAL_W      = 48;
  localparam int DIF_W      = 35;
  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ORD_W      = 2;
  localparam int SPW_W      = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER = 3'd0,
    CFG_WIDTH = 3'd1,
    CFG_BIAS  = 3'd2,
    CFG_SEED0 = 3'd3,
    CFG_SEED1 = 3'd4,
    CFG_SEED2 = 3'd5
  } cfg_idx_t;

  localparam logic [ORD_W-1:0] ORD_ONE   = 2'd1;
  localparam logic [ORD_W-1:0] ORD_TWO   = 2'd2;
  localparam logic [ORD_W-1:0] ORD_THREE = 2'd3;

  localparam logic [SPW_W-1:0] SPW_RESET = 6'd8;
  localparam logic [SPW_W-1:0] SPW_MAX   = 6'd32;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    acc_t sum;
    logic ovf;
  } sat_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic sat_t sat_add(acc_t a, acc_t b);
    logic signed [ACC_W:0] s;
    sat_t r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    r.ovf = s[ACC_W] ^ s[ACC_W-1];
    if (!r.ovf) begin
      r.sum = s[ACC_W-1:0];
    end else if (s[ACC_W]) begin
      r.sum = ACC_MIN;
    end else begin
      r.sum = ACC_MAX;
    end
    return r;
  endfunction

endpackage

[hw/rtl/spatial_difference_reconstruct_unit.sv]
// Spatial difference reconstruct unit: bias decode, seed emission, saturating integration.
// An item is held in the item stage; its final result goes to the output register.
// The first item of a field shows its order seed results first, one per cycle while
// the output is not stalled, and then its final result.
// Items are taken at one per cycle when no seeds are due and the output does not stall.
// Reset (rst_n low, synchronous): clears valids, accumulators and seed state,
// and loads the registers with order one, width eight, zero bias and seeds.
module spatial_difference_reconstruct_unit (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [sdr_pkg::WORD_W-1:0]               in_residual,
  input  logic [sdr_pkg::WORD_W-1:0]               in_group_ref,
  input  logic                                     in_last_in_field,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [sdr_pkg::VAL_W-1:0]         out_value,
  output logic                                     out_overflow,
  output logic                                     out_last,
  input  logic                                     cfg_we,
  input  logic [sdr_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [sdr_pkg::CFG_DATA_W-1:0]           cfg_data
);
  import sdr_pkg::*;

  // configuration
  logic [ORD_W-1:0]  order_r;
  logic [SPW_W-1:0]  width_r;
  logic [WORD_W-1:0] bias_r;
  logic [WORD_W-1:0] seed0_r;
  logic [WORD_W-1:0] seed1_r;
  logic [WORD_W-1:0] seed2_r;

  // item stage
  logic                    itm_vld_r;
  logic signed [DIF_W-1:0] itm_d_r;
  logic                    itm_last_r;
  logic [ORD_W-1:0]        seed_idx_r;
  logic                    seeds_sent_r;

  // accumulators
  acc_t lvl_r, slp_r, crv_r;

  // output register
  logic        out_valid_r;
  acc_t        out_value_r;
  logic        out_ovf_r;
  logic        out_last_r;

  logic [ORD_W-1:0]        eff_ord;
  logic [ORD_W-1:0]        ord_last;
  logic [SPW_W-1:0]        eff_w;
  logic [WORD_W:0]         mask_ext;
  logic [WORD_W-1:0]       wmask;
  logic [WORD_W-1:0]       thr;
  logic [WORD_W-1:0]       bw;
  logic signed [WORD_W:0]  bias_val;
  logic signed [DIF_W-1:0] d_nxt;

  acc_t s0, s1, s2, seed_val;
  acc_t lvl_ld, slp_ld, crv_ld;
  acc_t d_ext, slp_in, lvl_in;
  sat_t crv_sum, slp_sum, lvl_sum;
  acc_t lvl_nxt, slp_nxt, crv_nxt;
  logic ovf_nxt;

  logic out_free, seed_phase, emit, itm_done, seed_last, seed_load, in_fire;

  // effective order and width
  always_comb begin
    eff_ord  = (order_r == '0) ? ORD_ONE : order_r;
    ord_last = eff_ord - ORD_ONE;
    if (width_r == '0) begin
      eff_w = SPW_W'(1);
    end else if (width_r > SPW_MAX) begin
      eff_w = SPW_MAX;
    end else begin
      eff_w = width_r;
    end
    mask_ext = ((WORD_W+1)'(1) << eff_w) - (WORD_W+1)'(1);
    wmask    = mask_ext[WORD_W-1:0];
    thr      = WORD_W'(1) << (eff_w - SPW_W'(1));
  end

  // sign-magnitude bias decode and difference
  always_comb begin
    bw = bias_r & wmask;
    if (bw >= thr) begin
      bias_val = -$signed({1'b0, bw & ~thr});
    end else begin
      bias_val = $signed({1'b0, bw});
    end
    d_nxt = $signed({{(DIF_W-WORD_W){1'b0}}, in_residual})
          + $signed({{(DIF_W-WORD_W){1'b0}}, in_group_ref})
          + $signed({{(DIF_W-WORD_W-1){bias_val[WORD_W]}}, bias_val});
  end

  // seeds and accumulator load values
  always_comb begin
    s0 = $signed({{(ACC_W-WORD_W){1'b0}}, seed0_r & wmask});
    s1 = $signed({{(ACC_W-WORD_W){1'b0}}, seed1_r & wmask});
    s2 = $signed({{(ACC_W-WORD_W){1'b0}}, seed2_r & wmask});
    unique case (seed_idx_r)
      2'd0:    seed_val = s0;
      2'd1:    seed_val = s1;
      2'd2:    seed_val = s2;
      default: seed_val = s2;
    endcase
    crv_ld = '0;
    slp_ld = '0;
    unique case (eff_ord)
      ORD_TWO: begin
        lvl_ld = s1;
        slp_ld = s1 - s0;
      end
      ORD_THREE: begin
        lvl_ld = s2;
        slp_ld = s2 - s1;
        crv_ld = s2 - (s1 <<< 1) + s0;
      end
      default: lvl_ld = s0;
    endcase
  end

  // integration
  always_comb begin
    d_ext   = $signed({{(ACC_W-DIF_W){itm_d_r[DIF_W-1]}}, itm_d_r});
    crv_sum = sat_add(crv_r, d_ext);
    slp_in  = (eff_ord == ORD_THREE) ? crv_sum.sum : d_ext;
    slp_sum = sat_add(slp_r, slp_in);
    lvl_in  = (eff_ord == ORD_ONE) ? d_ext : slp_sum.sum;
    lvl_sum = sat_add(lvl_r, lvl_in);
    lvl_nxt = lvl_sum.sum;
    slp_nxt = (eff_ord == ORD_ONE) ? slp_r : slp_sum.sum;
    crv_nxt = (eff_ord == ORD_THREE) ? crv_sum.sum : crv_r;
    ovf_nxt = lvl_sum.ovf
            | ((eff_ord != ORD_ONE) & slp_sum.ovf)
            | ((eff_ord == ORD_THREE) & crv_sum.ovf);
  end

  // control
  always_comb begin
    out_free   = !out_valid_r || out_ready;
    seed_phase = itm_vld_r && !seeds_sent_r;
    emit       = itm_vld_r && out_free;
    itm_done   = emit && seeds_sent_r;
    seed_last  = (seed_idx_r == ord_last);
    seed_load  = emit && seed_phase && seed_last;
    in_ready   = !itm_vld_r || itm_done;
    in_fire    = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORD_ONE;
      width_r <= SPW_RESET;
      bias_r  <= '0;
      seed0_r <= '0;
      seed1_r <= '0;
      seed2_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORDER: order_r <= cfg_data[ORD_W-1:0];
        CFG_WIDTH: width_r <= cfg_data[SPW_W-1:0];
        CFG_BIAS:  bias_r  <= cfg_data[WORD_W-1:0];
        CFG_SEED0: seed0_r <= cfg_data[WORD_W-1:0];
        CFG_SEED1: seed1_r <= cfg_data[WORD_W-1:0];
        CFG_SEED2: seed2_r <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itm_vld_r    <= 1'b0;
      seed_idx_r   <= '0;
      seeds_sent_r <= 1'b0;
      lvl_r        <= '0;
      slp_r        <= '0;
      crv_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        itm_vld_r <= 1'b1;
      end else if (itm_done) begin
        itm_vld_r <= 1'b0;
      end
      if (emit && seed_phase) begin
        seed_idx_r <= seed_last ? '0 : seed_idx_r + ORD_W'(1);
      end
      if (seed_load) begin
        seeds_sent_r <= 1'b1;
        lvl_r        <= lvl_ld;
        slp_r        <= slp_ld;
        crv_r        <= crv_ld;
      end else if (itm_done) begin
        if (itm_last_r) begin
          seeds_sent_r <= 1'b0;
        end
        lvl_r <= lvl_nxt;
        slp_r <= slp_nxt;
        crv_r <= crv_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      itm_d_r    <= d_nxt;
      itm_last_r <= in_last_in_field;
    end
    if (emit) begin
      out_value_r <= seed_phase ? seed_val : lvl_nxt;
      out_ovf_r   <= !seed_phase && ovf_nxt;
      out_last_r  <= !seed_phase;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_overflow = out_ovf_r;
  assign out_last     = out_last_r;

  a_seed_idx_phase: assert property (@(posedge clk) disable iff (!rst_n)
    seed_idx_r != '0 |-> seed_phase)
    else $error("seed index moved outside seed phase");

  a_seed_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    seed_phase |-> seed_idx_r <= ord_last)
    else $error("seed index beyond order");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !itm_vld_r || itm_done)
    else $error("item stage overwritten");

  a_field_restart: assert property (@(posedge clk) disable iff (!rst_n)
    itm_done && itm_last_r |=> !seeds_sent_r)
    else $error("seed state not cleared at field end");

  a_ovf_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovf_r |-> out_last_r)
    else $error("overflow flagged on a seed result");

endmodule
